// ===== src/murmur3_x86_128_hash_unit_macros.svh =====
// Assertion helpers for the hash unit; all sample on clk and hold off
// while rst_n is low.
`ifndef MURMUR3_X86_128_HASH_UNIT_MACROS_SVH
`define MURMUR3_X86_128_HASH_UNIT_MACROS_SVH

// Concurrent check, disabled during reset.
`define MM3_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check: a then b in the next cycle.
`define MM3_CHECK_NEXT(label, a, b, msg) \
  `MM3_CHECK(label, (a) |=> (b), msg)

`endif

// ===== src/mm3_pkg.sv =====
package mm3_pkg;

  localparam logic [31:0] MIX_C1  = 32'h239b961b;
  localparam logic [31:0] MIX_C2  = 32'hab0e9789;
  localparam logic [31:0] MIX_C3  = 32'h38b34ae5;
  localparam logic [31:0] MIX_C4  = 32'ha1e38b93;
  localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
  localparam logic [31:0] LANE_ADD0 = 32'h561ccd1b;
  localparam logic [31:0] LANE_ADD1 = 32'h0bcaa747;
  localparam logic [31:0] LANE_ADD2 = 32'h96cd1c35;
  localparam logic [31:0] LANE_ADD3 = 32'h32ac3b17;

  localparam logic [4:0] FULL_BLOCK_BYTES = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL2,
    ST_MIXA,
    ST_MIXB,
    ST_TAIL,
    ST_FXOR,
    ST_FSUM,
    ST_FSPR,
    ST_FMIX1,
    ST_FMIX2,
    ST_MSUM,
    ST_MSPR
  } mm3_state_t;

  // Load enables for the two register stages of a lane pipe.
  typedef struct packed {
    logic ld1;
    logic ld2;
  } pipe_ctl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    return (v << r) | (v >> (6'd32 - {1'b0, r}));
  endfunction

  function automatic logic [31:0] key_mul_a(input logic [1:0] lane);
    logic [31:0] c;
    unique case (lane)
      2'd0:    c = MIX_C1;
      2'd1:    c = MIX_C2;
      2'd2:    c = MIX_C3;
      default: c = MIX_C4;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] key_mul_b(input logic [1:0] lane);
    logic [31:0] c;
    unique case (lane)
      2'd0:    c = MIX_C2;
      2'd1:    c = MIX_C3;
      2'd2:    c = MIX_C4;
      default: c = MIX_C1;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] key_rot(input logic [1:0] lane);
    return 5'd15 + {3'd0, lane};
  endfunction

  function automatic logic [4:0] lane_rot(input logic [1:0] lane);
    return 5'd19 - {2'd0, lane, 1'b0};
  endfunction

  function automatic logic [31:0] lane_add(input logic [1:0] lane);
    logic [31:0] c;
    unique case (lane)
      2'd0:    c = LANE_ADD0;
      2'd1:    c = LANE_ADD1;
      2'd2:    c = LANE_ADD2;
      default: c = LANE_ADD3;
    endcase
    return c;
  endfunction

  // Keeps the bytes of a lane word that lie below the byte count.
  function automatic logic [31:0] byte_mask(input logic [4:0] cnt, input logic [1:0] lane);
    logic [31:0] m;
    for (int b = 0; b < 4; b++) begin
      m[b*8 +: 8] = ({1'b0, lane, 2'(b)} < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // Body round for one lane: rotate, add neighbor, times five plus constant.
  function automatic logic [31:0] lane_update(input logic [31:0] h, input logic [31:0] k,
                                              input logic [31:0] nb, input logic [1:0] lane);
    logic [31:0] x;
    x = rotl32(h ^ k, lane_rot(lane)) + nb;
    return (x << 2) + x + lane_add(lane);
  endfunction

endpackage

// ===== src/mm3_key_lane.sv =====
module mm3_key_lane import mm3_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  lane_idx,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] key_in,
  output logic [31:0] key_out
);

  logic [31:0] p1_r;
  logic [31:0] k_r;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      p1_r <= key_in * key_mul_a(lane_idx);
    end
    if (ctl.ld2) begin
      k_r <= rotl32(p1_r, key_rot(lane_idx)) * key_mul_b(lane_idx);
    end
  end

  assign key_out = k_r;

endmodule

// ===== src/mm3_fmix_lane.sv =====
module mm3_fmix_lane import mm3_pkg::*; (
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] x_in,
  output logic [31:0] x_out
);

  logic [31:0] m1_r;
  logic [31:0] m2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      m1_r <= (x_in ^ (x_in >> 16)) * FMIX_C1;
    end
    if (ctl.ld2) begin
      m2_r <= (m1_r ^ (m1_r >> 13)) * FMIX_C2;
    end
  end

  assign x_out = m2_r ^ (m2_r >> 16);

endmodule

// ===== src/murmur3_x86_128_hash_unit.sv =====
// A new beat is taken only in idle, once the round for the previous block
// is done. The path to out_tvalid runs through the two multiply stages of
// the key lanes and the h0..h3 update chain (or the tail XOR for a short
// or empty last block), plus any wait for out_tready; finalization adds
// two fmix multiply stages.
// Reset (rst_n low, synchronous): seed 0, lanes 0, byte count 0, FSM idle.
`include "murmur3_x86_128_hash_unit_macros.svh"

module murmur3_x86_128_hash_unit import mm3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_word0..3 [127:0], valid_bytes [132:128], zeros
  input  logic         in_tlast,   // last_block
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // digest_word0..3, lowest bits first
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  mm3_state_t state_r, state_nxt;

  logic [31:0]       seed_r;
  logic [3:0][31:0]  hash_r, hash_nxt;
  logic [31:0]       total_r, total_nxt;
  logic              busy_r, busy_nxt;
  logic              last_r;
  logic              full_r;
  logic [3:0][31:0]  fw_r, fw_nxt;       // finalization work lanes
  logic              out_valid_r;
  logic [127:0]      out_data_r;
  logic              out_load;

  logic              accept;
  logic [4:0]        in_cnt;
  logic [4:0]        sat_cnt;
  logic [4:0]        eff_cnt;
  pipe_ctl_t         key_ctl;
  pipe_ctl_t         fmix_ctl;
  logic [3:0][31:0]  key_w;
  logic [3:0][31:0]  fm_w;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // A count above sixteen saturates; a block that is not last is always full.
  assign in_cnt  = in_tdata[132:128];
  assign sat_cnt = (in_cnt > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : in_cnt;
  assign eff_cnt = in_tlast ? sat_cnt : FULL_BLOCK_BYTES;

  // The first multiply loads straight off the accepted beat, which shortens
  // the body round.
  assign key_ctl.ld1  = accept;
  assign key_ctl.ld2  = (state_r == ST_MUL2);
  assign fmix_ctl.ld1 = (state_r == ST_FMIX1);
  assign fmix_ctl.ld2 = (state_r == ST_FMIX2);

  // Four key scramble lanes. Bytes past the count are zeroed; since a zero
  // key scrambles to zero, the tail XOR then leaves empty lanes untouched.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    mm3_key_lane u_key (
      .clk      (clk),
      .lane_idx (2'(g)),
      .ctl      (key_ctl),
      .key_in   (in_tdata[g*32 +: 32] & byte_mask(eff_cnt, 2'(g))),
      .key_out  (key_w[g])
    );

    mm3_fmix_lane u_fmix (
      .clk   (clk),
      .ctl   (fmix_ctl),
      .x_in  (fw_r[g]),
      .x_out (fm_w[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    total_nxt = total_r;
    busy_nxt  = busy_r;
    fw_nxt    = fw_r;
    out_load  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL2;
          total_nxt = total_r + {27'd0, eff_cnt};
          if (!in_tlast) begin
            busy_nxt = 1'b1;
          end
        end
      end
      ST_MUL2: begin
        state_nxt = (last_r && !full_r) ? ST_TAIL : ST_MIXA;
      end
      ST_MIXA: begin
        // h0..h2 see the old neighbor lanes
        for (int i = 0; i < 3; i++) begin
          hash_nxt[i] = lane_update(hash_r[i], key_w[i], hash_r[i+1], 2'(i));
        end
        state_nxt = ST_MIXB;
      end
      ST_MIXB: begin
        // h3 sees the updated h0
        hash_nxt[3] = lane_update(hash_r[3], key_w[3], hash_r[0], 2'd3);
        state_nxt   = last_r ? ST_FXOR : ST_IDLE;
      end
      ST_TAIL: begin
        for (int i = 0; i < 4; i++) begin
          hash_nxt[i] = hash_r[i] ^ key_w[i];
        end
        state_nxt = ST_FXOR;
      end
      ST_FXOR: begin
        // lanes move to the work set; reload for the next message
        for (int i = 0; i < 4; i++) begin
          fw_nxt[i]   = hash_r[i] ^ total_r;
          hash_nxt[i] = seed_r;
        end
        total_nxt = '0;
        busy_nxt  = 1'b0;
        state_nxt = ST_FSUM;
      end
      ST_FSUM: begin
        fw_nxt[0] = fw_r[0] + fw_r[1] + fw_r[2] + fw_r[3];
        state_nxt = ST_FSPR;
      end
      ST_FSPR: begin
        for (int i = 1; i < 4; i++) begin
          fw_nxt[i] = fw_r[i] + fw_r[0];
        end
        state_nxt = ST_FMIX1;
      end
      ST_FMIX1: begin
        state_nxt = ST_FMIX2;
      end
      ST_FMIX2: begin
        state_nxt = ST_MSUM;
      end
      ST_MSUM: begin
        fw_nxt    = fm_w;
        fw_nxt[0] = fm_w[0] + fm_w[1] + fm_w[2] + fm_w[3];
        state_nxt = ST_MSPR;
      end
      ST_MSPR: begin
        // merge lands in the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Seed write outside a message reloads the lanes at once.
    if (cfg_wr_en && !busy_r) begin
      for (int i = 0; i < 4; i++) begin
        hash_nxt[i] = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      hash_r      <= '0;
      total_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      total_r <= total_nxt;
      busy_r  <= busy_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fw_r <= fw_nxt;
    if (accept) begin
      last_r <= in_tlast;
      full_r <= (eff_cnt == FULL_BLOCK_BYTES);
    end
    if (out_load) begin
      out_data_r <= {fw_r[3] + fw_r[0], fw_r[2] + fw_r[0], fw_r[1] + fw_r[0], fw_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MM3_CHECK_NEXT(a_busy_after_body, accept && !in_tlast, busy_r, "body beat did not mark busy")
  `MM3_CHECK_NEXT(a_fin_clears, state_r == ST_FXOR, (total_r == '0) && !busy_r, "finalize did not clear count")
  `MM3_CHECK(a_out_from_merge, $rose(out_tvalid) |-> ($past(state_r) == ST_MSPR), "digest without merge")
  `MM3_CHECK_NEXT(a_merge_waits, (state_r == ST_MSPR) && out_valid_r && !out_tready, state_r == ST_MSPR, "merge dropped while output full")

endmodule
